>>> sv/adpm_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// adpm_pkg
// shared types and constants for the data-processing decode and move core
// ---------------------------------------------------------------------------
package adpm_pkg;

  typedef enum logic [3:0] {
    GRP_DPREG      = 4'd0,
    GRP_DPSREG     = 4'd1,
    GRP_MISC       = 4'd2,
    GRP_HALFMUL    = 4'd3,
    GRP_MUL        = 4'd4,
    GRP_SYNC       = 4'd5,
    GRP_EXTRALS    = 4'd6,
    GRP_EXTRALS_UP = 4'd7,
    GRP_DPIMM      = 4'd8,
    GRP_MOVW       = 4'd9,
    GRP_MOVT       = 4'd10,
    GRP_MSRHINTS   = 4'd11,
    GRP_ERROR      = 4'd12
  } group_t;

  // op1 patterns
  localparam logic [4:0] OP1_10XX0_MASK = 5'b11001;
  localparam logic [4:0] OP1_10XX0_VAL  = 5'b10000;
  localparam logic [4:0] OP1_0XX1X_MASK = 5'b10010;
  localparam logic [4:0] OP1_0XX1X_VAL  = 5'b00010;
  localparam logic [4:0] OP1_MSR_MASK   = 5'b11011;
  localparam logic [4:0] OP1_MSR_VAL    = 5'b10010;
  localparam logic [4:0] OP1_MOVW       = 5'b10000;
  localparam logic [4:0] OP1_MOVT       = 5'b10100;

  // op2 patterns
  localparam logic [3:0] OP2_MUL        = 4'b1001;
  localparam logic [3:0] OP2_XLS_HALF   = 4'b1011;
  localparam logic [3:0] OP2_XLS_DUAL   = 4'b1101;

  localparam logic [3:0] OPC_MOV        = 4'b1101;
  localparam logic [3:0] REG_PC         = 4'd15;
  localparam logic [3:0] COND_NV        = 4'b1111;

  typedef struct packed {
    logic [31:0] instruction;
    logic [3:0]  flags_nzcv;
    logic [31:0] dest_current;
  } insn_t;

  typedef struct packed {
    group_t      group;
    logic        write_reg;
    logic [3:0]  dest_reg;
    logic [31:0] write_value;
    logic        write_pc;
    logic        flags_write;
    logic        new_n;
    logic        new_z;
    logic        new_c;
  } res_t;

endpackage
`default_nettype wire

>>> sv/adpm_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// adpm_insn_if / adpm_res_if
// valid/ready channels for instruction items and result items
// ---------------------------------------------------------------------------
interface adpm_insn_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;
  logic [3:0]  flags_nzcv;
  logic [31:0] dest_current;

  modport source (output valid, instruction, flags_nzcv, dest_current, input ready);
  modport sink   (input valid, instruction, flags_nzcv, dest_current, output ready);
endinterface

interface adpm_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  group;
  logic        write_reg;
  logic [3:0]  dest_reg;
  logic [31:0] write_value;
  logic        write_pc;
  logic        flags_write;
  logic        new_n;
  logic        new_z;
  logic        new_c;

  modport source (output valid, group, write_reg, dest_reg, write_value, write_pc,
                  flags_write, new_n, new_z, new_c, input ready);
  modport sink   (input valid, group, write_reg, dest_reg, write_value, write_pc,
                  flags_write, new_n, new_z, new_c, output ready);
endinterface
`default_nettype wire

>>> sv/arm_dpmisc_decode_and_move_imm_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// arm_dpmisc_decode_and_move_imm_core
// data-processing/misc group decode with MOV/MOVW/MOVT execution
//
//   channel  role  payload
//   insn     sink  instruction, flags_nzcv, dest_current
//   result   src   group, write_reg, dest_reg, write_value, write_pc,
//                  flags_write, new_n, new_z, new_c
//
// one instruction per cycle unless result.ready stalls the pipeline; an
// instruction passes stage one and stage two before its result is valid
// stage one registers the instruction, stage two registers the decoded result
// a stalled result holds both stages; insn.ready drops only when both are full
// reset clears the two stage valid bits, payload registers are not reset
// ---------------------------------------------------------------------------
module arm_dpmisc_decode_and_move_imm_core
  import adpm_pkg::*;
(
  input  wire           clk,
  input  wire           rst,
  adpm_insn_if.sink     insn,
  adpm_res_if.source    result
);

  logic  s1_valid;
  insn_t s1_data;
  logic  s1_ready;
  logic  s2_valid;
  res_t  s2_data;
  logic  s2_ready;
  res_t  dec;

  assign s2_ready   = !s2_valid || result.ready;
  assign s1_ready   = !s1_valid || s2_ready;
  assign insn.ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= insn.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && insn.valid) begin
      s1_data.instruction  <= insn.instruction;
      s1_data.flags_nzcv   <= insn.flags_nzcv;
      s1_data.dest_current <= insn.dest_current;
    end
  end

  adpm_exec u_exec (
    .insn (s1_data),
    .res  (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_data <= dec;
    end
  end

  assign result.valid       = s2_valid;
  assign result.group       = s2_data.group;
  assign result.write_reg   = s2_data.write_reg;
  assign result.dest_reg    = s2_data.dest_reg;
  assign result.write_value = s2_data.write_value;
  assign result.write_pc    = s2_data.write_pc;
  assign result.flags_write = s2_data.flags_write;
  assign result.new_n       = s2_data.new_n;
  assign result.new_z       = s2_data.new_z;
  assign result.new_c       = s2_data.new_c;

  a_wr_excl: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> !(s2_data.write_reg && s2_data.write_pc))
    else $error("register and pc write together");

  a_pc_dest: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_data.write_pc) |-> (s2_data.dest_reg == REG_PC))
    else $error("pc write without register 15");

  a_flags_mov: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_data.flags_write) |-> (s2_data.write_reg && s2_data.group == GRP_DPIMM))
    else $error("flag update outside an executed mov");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_valid && !result.ready) |-> !insn.ready)
    else $error("transfer taken with both stages blocked");

endmodule
`default_nettype wire

>>> sv/adpm_exec.sv
`default_nettype none
// ---------------------------------------------------------------------------
// adpm_exec
// group decode, condition check and move-immediate execution
// ---------------------------------------------------------------------------
module adpm_exec
  import adpm_pkg::*;
(
  input  insn_t insn,
  output res_t  res
);

  logic [31:0] ins;
  logic [4:0]  op1;
  logic [3:0]  op2;
  logic        a10xx0;
  logic        a0xx1x;
  logic        hi;
  logic        b_ext;
  logic        n, z, c, v;
  logic        cond_base;
  logic        pass;
  group_t      grp;
  logic [3:0]  rd;
  logic [15:0] imm16;
  logic [4:0]  rot;
  logic [63:0] rot_wide;
  logic [31:0] imm_rot;
  logic        is_mov;
  logic        exec;
  logic [31:0] val;

  assign ins    = insn.instruction;
  assign op1    = ins[24:20];
  assign op2    = ins[7:4];
  assign a10xx0 = (op1 & OP1_10XX0_MASK) == OP1_10XX0_VAL;
  assign a0xx1x = (op1 & OP1_0XX1X_MASK) == OP1_0XX1X_VAL;
  assign hi     = op1[4];
  assign b_ext  = (op2 == OP2_XLS_HALF) || ((op2 & OP2_XLS_DUAL) == OP2_XLS_DUAL);
  assign {n, z, c, v} = insn.flags_nzcv;

  // condition check
  always_comb begin
    unique case (ins[31:29])
      3'd0:    cond_base = z;
      3'd1:    cond_base = c;
      3'd2:    cond_base = n;
      3'd3:    cond_base = v;
      3'd4:    cond_base = c && !z;
      3'd5:    cond_base = (n == v);
      3'd6:    cond_base = (n == v) && !z;
      default: cond_base = 1'b1;
    endcase
    pass = (ins[28] && ins[31:28] != COND_NV) ? !cond_base : cond_base;
  end

  // group decode
  always_comb begin
    if (!ins[25]) begin
      priority if (!a10xx0 && !op2[0])                 grp = GRP_DPREG;
      else if (!a10xx0 && op2[3] == 1'b0 && op2[0])    grp = GRP_DPSREG;
      else if (a10xx0 && !op2[3])                      grp = GRP_MISC;
      else if (a10xx0 && op2[3] && !op2[0])            grp = GRP_HALFMUL;
      else if (!hi && op2 == OP2_MUL)                  grp = GRP_MUL;
      else if (hi && op2 == OP2_MUL)                   grp = GRP_SYNC;
      else if (!a0xx1x && b_ext)                       grp = GRP_EXTRALS;
      else if (a0xx1x && b_ext)                        grp = GRP_EXTRALS_UP;
      else                                             grp = GRP_ERROR;
    end else begin
      priority if (!a10xx0)                            grp = GRP_DPIMM;
      else if (op1 == OP1_MOVW)                        grp = GRP_MOVW;
      else if (op1 == OP1_MOVT)                        grp = GRP_MOVT;
      else if ((op1 & OP1_MSR_MASK) == OP1_MSR_VAL)    grp = GRP_MSRHINTS;
      else                                             grp = GRP_ERROR;
    end
  end

  // immediate expansion
  assign rd       = ins[15:12];
  assign imm16    = {ins[19:16], ins[11:0]};
  assign rot      = {ins[11:8], 1'b0};
  assign rot_wide = {24'd0, ins[7:0], 24'd0, ins[7:0]} >> rot;
  assign imm_rot  = rot_wide[31:0];
  assign is_mov   = (grp == GRP_DPIMM) && (ins[24:21] == OPC_MOV);

  always_comb begin
    exec = 1'b0;
    val  = 32'd0;
    unique case (grp)
      GRP_DPIMM: begin
        if (is_mov && pass) begin
          exec = 1'b1;
          val  = imm_rot;
        end
      end
      GRP_MOVW: begin
        if (pass) begin
          exec = 1'b1;
          val  = {16'd0, imm16};
        end
      end
      GRP_MOVT: begin
        if (pass) begin
          exec = 1'b1;
          val  = {imm16, insn.dest_current[15:0]};
        end
      end
      default: begin
        exec = 1'b0;
      end
    endcase
  end

  always_comb begin
    res.group       = grp;
    res.dest_reg    = rd;
    res.write_value = val;
    res.write_reg   = exec && (rd != REG_PC);
    res.write_pc    = exec && (rd == REG_PC);
    res.flags_write = is_mov && pass && ins[20] && (rd != REG_PC);
    res.new_n       = n;
    res.new_z       = z;
    res.new_c       = c;
    if (res.flags_write) begin
      res.new_n = val[31];
      res.new_z = (val == 32'd0);
      res.new_c = (rot == 5'd0) ? c : val[31];
    end
  end

endmodule
`default_nettype wire
